// ===== rtl/thp_pkg.sv =====
package thp_pkg;

	localparam int TEMP_W = 12;
	localparam int CNT_W  = 8;
	localparam int TICK_W = 16;
	localparam int REG_W  = 32;
	localparam int ADDR_W = 5;
	localparam int RIDX_W = 3;

	typedef enum logic [1:0] {
		OP_MOTOR_ADC = 2'd0,
		OP_IPM_ADC   = 2'd1,
		OP_TICK      = 2'd2,
		OP_CLEAR     = 2'd3
	} op_t;

	// register indexes, byte address = 4 * index
	localparam logic [RIDX_W-1:0] REG_WIN_LO       = 3'd0;
	localparam logic [RIDX_W-1:0] REG_WIN_HI       = 3'd1;
	localparam logic [RIDX_W-1:0] REG_STABLE_CNT   = 3'd2;
	localparam logic [RIDX_W-1:0] REG_IPM_TRIP     = 3'd3;
	localparam logic [RIDX_W-1:0] REG_IPM_RECOVER  = 3'd4;
	localparam logic [RIDX_W-1:0] REG_MOTOR_TRIP   = 3'd5;
	localparam logic [RIDX_W-1:0] REG_MOTOR_RECOVER = 3'd6;
	localparam logic [RIDX_W-1:0] REG_MOTOR_DELAY  = 3'd7;

	// reset values
	localparam int ADC_WIN_MARGIN = 50;
	localparam logic [CNT_W-1:0]         STABLE_CNT_RST    = 8'd5;
	localparam logic signed [TEMP_W-1:0] IPM_TRIP_RST      = 12'sd1050;
	localparam logic signed [TEMP_W-1:0] IPM_RECOVER_RST   = 12'sd900;
	localparam logic signed [TEMP_W-1:0] MOTOR_TRIP_RST    = 12'sd1200;
	localparam logic signed [TEMP_W-1:0] MOTOR_RECOVER_RST = 12'sd1000;
	localparam logic [TICK_W-1:0]        MOTOR_DELAY_RST   = 16'd100;

	typedef struct packed {
		logic [CNT_W-1:0]         stable_cnt;
		logic signed [TEMP_W-1:0] ipm_trip;
		logic signed [TEMP_W-1:0] ipm_recover;
		logic signed [TEMP_W-1:0] motor_trip;
		logic signed [TEMP_W-1:0] motor_recover;
		logic [TICK_W-1:0]        motor_delay;
	} prot_cfg_t;

	typedef struct packed {
		logic stop;
		logic latched;
		logic can_recover;
	} prot_status_t;

endpackage

// ===== rtl/thp_cfg_regs.sv =====
module thp_cfg_regs
	import thp_pkg::*;
#(
	parameter int ADC_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [REG_W-1:0]    pwdata,
	output logic [REG_W-1:0]    prdata,
	output logic                pready,
	output logic [ADC_BITS-1:0] win_lo,
	output logic [ADC_BITS-1:0] win_hi,
	output prot_cfg_t           cfg
);

	localparam logic [ADC_BITS-1:0] WIN_LO_RST = ADC_BITS'(ADC_WIN_MARGIN);
	localparam logic [ADC_BITS-1:0] WIN_HI_RST =
		ADC_BITS'((2 ** ADC_BITS) - 1 - ADC_WIN_MARGIN);

	logic [ADC_BITS-1:0] win_lo_q, win_hi_q;
	prot_cfg_t           cfg_q;
	logic                wr_en;
	logic [RIDX_W-1:0]   ridx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign ridx   = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_lo_q              <= WIN_LO_RST;
			win_hi_q              <= WIN_HI_RST;
			cfg_q.stable_cnt      <= STABLE_CNT_RST;
			cfg_q.ipm_trip        <= IPM_TRIP_RST;
			cfg_q.ipm_recover     <= IPM_RECOVER_RST;
			cfg_q.motor_trip      <= MOTOR_TRIP_RST;
			cfg_q.motor_recover   <= MOTOR_RECOVER_RST;
			cfg_q.motor_delay     <= MOTOR_DELAY_RST;
		end else if (wr_en) begin
			case (ridx)
				REG_WIN_LO:        win_lo_q            <= pwdata[ADC_BITS-1:0];
				REG_WIN_HI:        win_hi_q            <= pwdata[ADC_BITS-1:0];
				REG_STABLE_CNT:    cfg_q.stable_cnt    <= pwdata[CNT_W-1:0];
				REG_IPM_TRIP:      cfg_q.ipm_trip      <= pwdata[TEMP_W-1:0];
				REG_IPM_RECOVER:   cfg_q.ipm_recover   <= pwdata[TEMP_W-1:0];
				REG_MOTOR_TRIP:    cfg_q.motor_trip    <= pwdata[TEMP_W-1:0];
				REG_MOTOR_RECOVER: cfg_q.motor_recover <= pwdata[TEMP_W-1:0];
				REG_MOTOR_DELAY:   cfg_q.motor_delay   <= pwdata[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// signed levels read back sign-extended
	always_comb begin
		case (ridx)
			REG_WIN_LO:        prdata = REG_W'(win_lo_q);
			REG_WIN_HI:        prdata = REG_W'(win_hi_q);
			REG_STABLE_CNT:    prdata = REG_W'(cfg_q.stable_cnt);
			REG_IPM_TRIP:      prdata = REG_W'(cfg_q.ipm_trip);
			REG_IPM_RECOVER:   prdata = REG_W'(cfg_q.ipm_recover);
			REG_MOTOR_TRIP:    prdata = REG_W'(cfg_q.motor_trip);
			REG_MOTOR_RECOVER: prdata = REG_W'(cfg_q.motor_recover);
			REG_MOTOR_DELAY:   prdata = REG_W'(cfg_q.motor_delay);
			default:           prdata = '0;
		endcase
	end

	assign win_lo = win_lo_q;
	assign win_hi = win_hi_q;
	assign cfg    = cfg_q;

endmodule

// ===== rtl/thp_debounce.sv =====
module thp_debounce
	import thp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             good,
	input  logic [CNT_W-1:0] stable_cnt,
	output logic             ok
);

	logic             valid_q, valid_nxt;
	logic [CNT_W-1:0] cnt_q, cnt_nxt, cnt_inc;

	assign cnt_inc = (cnt_q < stable_cnt) ? cnt_q + CNT_W'(1) : cnt_q;

	always_comb begin
		valid_nxt = valid_q;
		cnt_nxt   = '0;
		if (good != valid_q) begin
			if (cnt_inc >= stable_cnt) begin
				valid_nxt = good;
			end else begin
				cnt_nxt = cnt_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b1;
			cnt_q   <= '0;
		end else if (en) begin
			valid_q <= valid_nxt;
			cnt_q   <= cnt_nxt;
		end
	end

	// flag as it stands after this sample
	assign ok = en ? valid_nxt : valid_q;

endmodule

// ===== rtl/thp_tick_ctrl.sv =====
module thp_tick_ctrl
	import thp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  op_t                      op,
	input  logic signed [TEMP_W-1:0] motor_temp,
	input  logic signed [TEMP_W-1:0] module_temp,
	input  logic                     sensors_ok,
	input  prot_cfg_t                cfg,
	output prot_status_t             status
);

	logic [TICK_W-1:0]        ticks_q, ticks_nxt, ticks_inc;
	logic                     latched_q, latched_nxt;
	logic signed [TEMP_W-1:0] mt_q, mt_nxt, it_q, it_nxt;
	logic                     stop;

	assign ticks_inc = (ticks_q != '1) ? ticks_q + TICK_W'(1) : ticks_q;

	always_comb begin
		ticks_nxt   = ticks_q;
		latched_nxt = latched_q;
		mt_nxt      = mt_q;
		it_nxt      = it_q;
		stop        = 1'b0;
		case (op)
			OP_TICK: begin
				mt_nxt = motor_temp;
				it_nxt = module_temp;
				// sensor fault first, then module trip, then motor delay
				if (!sensors_ok) begin
					stop = 1'b1;
				end else if (module_temp >= cfg.ipm_trip) begin
					stop = 1'b1;
				end else if (motor_temp >= cfg.motor_trip) begin
					ticks_nxt = ticks_inc;
					stop      = (ticks_inc >= cfg.motor_delay);
				end else begin
					ticks_nxt = '0;
				end
				if (stop) begin
					latched_nxt = 1'b1;
				end
			end
			OP_CLEAR: begin
				ticks_nxt   = '0;
				latched_nxt = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q   <= '0;
			latched_q <= 1'b0;
			mt_q      <= '0;
			it_q      <= '0;
		end else if (en) begin
			ticks_q   <= ticks_nxt;
			latched_q <= latched_nxt;
			mt_q      <= mt_nxt;
			it_q      <= it_nxt;
		end
	end

	assign status.stop        = stop;
	assign status.latched     = latched_nxt;
	assign status.can_recover = sensors_ok && (it_nxt <= cfg.ipm_recover) &&
	                            (mt_nxt <= cfg.motor_recover);

endmodule

// ===== rtl/thermal_protection_supervisor_unit.sv =====
// Channel   Dir  Transaction contents
// s_axis    in   tuser: op; tdata: adc_sample, motor_temp, module_temp
// m_axis    out  tdata: window, stop, latched, recover, motor ok, ipm ok
// apb       cfg  eight 32-bit registers at byte offsets 0x00..0x1C
//
// One event per cycle sustained while m_tready stays high; an accepted event
// passes through the input register, then decision logic into the result register.
// Sensor flags, tick count and latch update when an event moves into the
// result register, so back-to-back events see each other's effects.
// Reset loads the register defaults, marks both sensors valid and drops the
// latch; no clearing pass. m_tready low holds the result and stalls the
// input register; s_tready drops only when both stages are full.
module thermal_protection_supervisor_unit
	import thp_pkg::*;
#(
	parameter int ADC_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	// slave stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [1:0]          s_tuser,  // [1:0] op
	// adc_sample, motor_temp, module_temp, zero pad
	input  logic [((ADC_BITS + 2 * TEMP_W + 7) / 8) * 8 - 1:0] s_tdata,
	// master stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,  // sample_in_window, trip_event,
	                                      // emergency_latched, can_recover,
	                                      // motor_sensor_ok, ipm_sensor_ok, zero pad
	// config
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [REG_W-1:0]    pwdata,
	output logic [REG_W-1:0]    prdata,
	output logic                pready
);

	logic [ADC_BITS-1:0] win_lo, win_hi;
	prot_cfg_t           cfg;

	thp_cfg_regs #(
		.ADC_BITS (ADC_BITS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.win_lo  (win_lo),
		.win_hi  (win_hi),
		.cfg     (cfg)
	);

	// input register
	logic                     vld_s1;
	op_t                      op_s1;
	logic [ADC_BITS-1:0]      adc_s1;
	logic signed [TEMP_W-1:0] mt_s1, it_s1;
	logic                     take, adv;

	// result register
	logic       res_vld_q;
	logic [7:0] res_q;

	assign adv      = vld_s1 && (!res_vld_q || m_tready);
	assign s_tready = !vld_s1 || adv;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1  <= op_t'(s_tuser);
			adc_s1 <= s_tdata[ADC_BITS-1:0];
			mt_s1  <= s_tdata[ADC_BITS +: TEMP_W];
			it_s1  <= s_tdata[ADC_BITS+TEMP_W +: TEMP_W];
		end
	end

	// decision logic
	logic         is_adc, in_win, motor_ok, ipm_ok;
	prot_status_t status;

	assign is_adc = (op_s1 == OP_MOTOR_ADC) || (op_s1 == OP_IPM_ADC);
	assign in_win = (adc_s1 >= win_lo) && (adc_s1 <= win_hi);

	thp_debounce u_motor_db (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv && (op_s1 == OP_MOTOR_ADC)),
		.good       (in_win),
		.stable_cnt (cfg.stable_cnt),
		.ok         (motor_ok)
	);

	thp_debounce u_ipm_db (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv && (op_s1 == OP_IPM_ADC)),
		.good       (in_win),
		.stable_cnt (cfg.stable_cnt),
		.ok         (ipm_ok)
	);

	thp_tick_ctrl u_tick (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv),
		.op          (op_s1),
		.motor_temp  (mt_s1),
		.module_temp (it_s1),
		.sensors_ok  (motor_ok && ipm_ok),
		.cfg         (cfg),
		.status      (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (adv) begin
			res_vld_q <= 1'b1;
		end else if (m_tready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= {2'b00, ipm_ok, motor_ok, status.can_recover,
			          status.latched, status.stop, is_adc && in_win};
		end
	end

	assign m_tvalid = res_vld_q;
	assign m_tdata  = res_q;

	// checks
	a_stop_latches: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q && res_q[1] |-> res_q[2])
		else $error("stop without latch");

	a_recover_needs_sensors: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q && res_q[3] |-> res_q[4] && res_q[5])
		else $error("recover with invalid sensor");

	a_clear_drops_latch: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (op_s1 == OP_CLEAR) |=> res_vld_q && !res_q[2] && !res_q[1])
		else $error("clear left latch set");

	a_window_only_adc: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !is_adc |=> !res_q[0])
		else $error("window flag on non-sample event");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q && !m_tready |=> res_vld_q && $stable(res_q))
		else $error("stalled result changed");

endmodule
